// ===== sv/tat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_pkg
// Shared constants, codes and control types of the timed allocation table.
// ----------------------------------------------------------------------------
package tat_pkg;

	localparam int Capacity = 16;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_INSERTED  = 3'd0,
		K_FULL      = 3'd1,
		K_DELETED   = 3'd2,
		K_NOT_FOUND = 3'd3,
		K_FOUND     = 3'd4,
		K_FINISHED  = 3'd5,
		K_TICK_DONE = 3'd6
	} kind_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic do_insert;
		logic do_remove;
		logic do_dec;
		logic emit;
	} tat_cmd_t;

	typedef struct packed {
		logic full;
		logic scan_end;
		logic hit;
	} tat_stat_t;

endpackage
`default_nettype wire

// ===== sv/timed_allocation_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timed_allocation_table
// Size-ordered table of allocated segments with ids and run-time countdown.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Results appear with
// valid high for one cycle each and cannot be stalled; the last one of a
// command has last set. A command walks the slots one per cycle, except that
// a tick pauses in S_ACT after each finished segment; a tick also first counts
// all run times down in S_DEC before its walk.
module timed_allocation_table import tat_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] seg_start,
	input  wire logic [15:0] seg_end,
	input  wire logic [15:0] run_time,
	input  wire logic [15:0] query_id,
	output logic             valid,
	output logic [2:0]       kind,
	output logic [15:0]      seg_id,
	output logic [15:0]      out_start,
	output logic [15:0]      out_end,
	output logic [15:0]      remaining,
	output logic             last
);

	tat_cmd_t cmd;
	tat_stat_t stat;

	tat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	tat_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(op),
		.seg_start(seg_start), .seg_end(seg_end), .run_time(run_time),
		.query_id(query_id), .stat(stat), .res_valid_q(valid),
		.kind_q(kind), .seg_id_q(seg_id), .start_q(out_start),
		.end_q(out_end), .rem_q(remaining), .last_q(last)
	);

endmodule
`default_nettype wire

// ===== sv/tat_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_datapath
// Slot registers, request registers, scan pointer and result register.
// ----------------------------------------------------------------------------
module tat_datapath import tat_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tat_cmd_t    cmd,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] seg_start,
	input  wire logic [15:0] seg_end,
	input  wire logic [15:0] run_time,
	input  wire logic [15:0] query_id,
	output tat_stat_t        stat,
	output logic             res_valid_q,
	output logic [2:0]       kind_q,
	output logic [15:0]      seg_id_q,
	output logic [15:0]      start_q,
	output logic [15:0]      end_q,
	output logic [15:0]      rem_q,
	output logic             last_q
);

	logic [15:0] id_q [Capacity];
	logic [15:0] st_q [Capacity];
	logic [15:0] en_q [Capacity];
	logic [15:0] tm_q [Capacity];
	logic [CntW-1:0] used_q;
	logic [15:0] next_id_q;
	logic [1:0] op_q;
	logic [15:0] rst_q, ren_q, rrt_q, rqid_q;
	logic [CntW-1:0] ptr_q;
	logic [IdxW-1:0] pi;
	logic [16:0] nsize, csize;
	logic in_range;

	assign pi = ptr_q[IdxW-1:0];
	assign in_range = ptr_q < used_q;
	assign nsize = {1'b0, ren_q} - {1'b0, rst_q};
	assign csize = {1'b0, en_q[pi]} - {1'b0, st_q[pi]};

	always_comb begin
		stat.full = used_q == CntW'(Capacity);
		stat.scan_end = !in_range;
		unique case (op_t'(op_q))
			OP_INSERT: stat.hit = $signed(nsize) < $signed(csize);
			OP_DELETE, OP_SEARCH: stat.hit = id_q[pi] == rqid_q;
			OP_TICK: stat.hit = tm_q[pi] == 16'd0;
			default: stat.hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			rst_q <= seg_start;
			ren_q <= seg_end;
			rrt_q <= run_time;
			rqid_q <= query_id;
		end
		for (int i = 0; i < Capacity; i++) begin
			if (cmd.do_dec && tm_q[i] != 16'd0) begin
				tm_q[i] <= tm_q[i] - 16'd1;
			end
			if (cmd.do_insert && IdxW'(i) == pi) begin
				id_q[i] <= next_id_q;
				st_q[i] <= rst_q;
				en_q[i] <= ren_q;
				tm_q[i] <= rrt_q;
			end
		end
		for (int i = 1; i < Capacity; i++) begin
			if (cmd.do_insert && IdxW'(i) > pi) begin
				id_q[i] <= id_q[i-1];
				st_q[i] <= st_q[i-1];
				en_q[i] <= en_q[i-1];
				tm_q[i] <= tm_q[i-1];
			end
		end
		for (int i = 0; i < Capacity - 1; i++) begin
			if (cmd.do_remove && IdxW'(i) >= pi) begin
				id_q[i] <= id_q[i+1];
				st_q[i] <= st_q[i+1];
				en_q[i] <= en_q[i+1];
				tm_q[i] <= tm_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			next_id_q <= '0;
			ptr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.do_insert || cmd.do_remove || cmd.emit;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + CntW'(1);
			end
			if (cmd.do_insert) begin
				used_q <= used_q + CntW'(1);
				next_id_q <= next_id_q + 16'd1;
			end
			if (cmd.do_remove) begin
				used_q <= used_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			kind_q <= K_INSERTED;
			seg_id_q <= next_id_q;
			start_q <= rst_q;
			end_q <= ren_q;
			rem_q <= rrt_q;
			last_q <= 1'b1;
		end else if (cmd.do_remove) begin
			seg_id_q <= id_q[pi];
			start_q <= st_q[pi];
			end_q <= en_q[pi];
			if (op_t'(op_q) == OP_TICK) begin
				kind_q <= K_FINISHED;
				rem_q <= '0;
				last_q <= 1'b0;
			end else begin
				kind_q <= K_DELETED;
				rem_q <= tm_q[pi];
				last_q <= 1'b1;
			end
		end else if (op_t'(op_q) == OP_SEARCH && in_range) begin
			kind_q <= K_FOUND;
			seg_id_q <= id_q[pi];
			start_q <= st_q[pi];
			end_q <= en_q[pi];
			rem_q <= tm_q[pi];
			last_q <= 1'b1;
		end else if (op_t'(op_q) == OP_INSERT) begin
			kind_q <= K_FULL;
			seg_id_q <= '0;
			start_q <= rst_q;
			end_q <= ren_q;
			rem_q <= rrt_q;
			last_q <= 1'b1;
		end else if (op_t'(op_q) == OP_TICK) begin
			kind_q <= K_TICK_DONE;
			seg_id_q <= '0;
			start_q <= '0;
			end_q <= '0;
			rem_q <= '0;
			last_q <= 1'b1;
		end else begin
			kind_q <= K_NOT_FOUND;
			seg_id_q <= rqid_q;
			start_q <= '0;
			end_q <= '0;
			rem_q <= '0;
			last_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/tat_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer that walks the slots for each command and issues result steps.
// ----------------------------------------------------------------------------
module tat_ctrl import tat_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] op,
	input  wire tat_stat_t  stat,
	output tat_cmd_t        cmd,
	output logic            busy
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_SCAN = 5'b00100,
		S_ACT  = 5'b01000,
		S_WAIT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic go;

	assign go = start && !busy;
	assign busy = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (go) begin
					cmd.load = 1'b1;
					state_d = (op_t'(op) == OP_TICK) ? S_DEC : S_SCAN;
				end
			end
			S_DEC: begin
				cmd.do_dec = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				unique case (op_t'(op_q))
					OP_INSERT: begin
						if (stat.full) begin
							cmd.emit = 1'b1;
							state_d = S_WAIT;
						end else if (stat.scan_end || stat.hit) begin
							cmd.do_insert = 1'b1;
							state_d = S_WAIT;
						end else begin
							cmd.scan_step = 1'b1;
						end
					end
					OP_DELETE: begin
						if (stat.scan_end) begin
							cmd.emit = 1'b1;
							state_d = S_WAIT;
						end else if (stat.hit) begin
							cmd.do_remove = 1'b1;
							state_d = S_WAIT;
						end else begin
							cmd.scan_step = 1'b1;
						end
					end
					OP_SEARCH: begin
						if (stat.scan_end || stat.hit) begin
							cmd.emit = 1'b1;
							state_d = S_WAIT;
						end else begin
							cmd.scan_step = 1'b1;
						end
					end
					OP_TICK: begin
						if (stat.scan_end) begin
							cmd.emit = 1'b1;
							state_d = S_WAIT;
						end else if (stat.hit) begin
							cmd.do_remove = 1'b1;
							state_d = S_ACT;
						end else begin
							cmd.scan_step = 1'b1;
						end
					end
					default: state_d = S_WAIT;
				endcase
			end
			S_ACT: state_d = S_SCAN;
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				op_q <= op;
			end
		end
	end

endmodule
`default_nettype wire
